### sv/ascii_integer_token_parser_macros.svh
// ----------------------------------------------------------------------------
// ascii_integer_token_parser_macros
// assertion macros shared by the token parser rtl
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_TOKEN_PARSER_MACROS_SVH
`define ASCII_INTEGER_TOKEN_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AITP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token parser check failed");

// next-cycle implication, disabled while reset is low
`define AITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token parser check failed");

`endif

### sv/aitp_pkg.sv
// ----------------------------------------------------------------------------
// aitp_pkg
// constants and types for the ascii integer token parser
// ----------------------------------------------------------------------------
`default_nettype none

package aitp_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_mode;

    // number modes
    localparam t_mode MODE_SDEC = 2'd0;
    localparam t_mode MODE_UDEC = 2'd1;
    localparam t_mode MODE_HEX  = 2'd2;

    // character codes
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_F     = 8'h46;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_VT    = 8'h0B;
    localparam t_byte CH_FF    = 8'h0C;
    localparam t_byte CH_CR    = 8'h0D;

    function automatic logic is_blank(input t_byte b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

`default_nettype wire

### sv/ascii_integer_token_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_token_parser
// parses signed/unsigned decimal and upper-case hex integer tokens from a
// byte stream, one byte per transfer, one result per finished token
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  ---------+-----------+----------------------------------------------------
//  input    | sink      | i_valid o_ready i_char_byte i_number_mode
//  result   | source    | o_valid i_ready o_number_value o_token_valid
//           |           | o_end_byte
//
//  one byte per cycle sustained, but a stalled result holds a byte ending a
//  token; input register, then token logic, then the result register
//  the token state loop is one shift-add of VALUE_WIDTH bits per cycle
//  synchronous active-low reset clears token state and both valid flags
//  a stalled result blocks only bytes that end a token; digits keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_token_parser #(
    parameter int unsigned VALUE_WIDTH = aitp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_char_byte,
    input  wire logic [1:0]                    i_number_mode,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [VALUE_WIDTH-1:0]      o_number_value,
    output logic                               o_token_valid,
    output logic [7:0]                         o_end_byte
);

    import aitp_pkg::*;

    `include "ascii_integer_token_parser_macros.svh"

    // input register
    logic                   r_in_valid;
    t_byte                  r_byte;
    t_mode                  r_mode;

    // token state
    logic                   r_in_token;
    logic                   r_minus;
    logic [VALUE_WIDTH-1:0] r_acc;

    // result register
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_tvalid;
    t_byte                  r_out_byte;

    logic                   w_hex;
    logic                   w_signed;
    logic                   w_is_dig;
    logic                   w_is_hexl;
    logic                   w_skip;
    logic                   w_minus;
    logic                   w_emit;
    logic                   w_advance;
    logic [3:0]             w_digit;
    logic [VALUE_WIDTH-1:0] w_digit_ext;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic [VALUE_WIDTH-1:0] w_value;

    always_comb begin
        w_hex     = r_mode[1];
        w_signed  = (r_mode == MODE_SDEC);
        w_is_dig  = (r_byte >= CH_0) && (r_byte <= CH_9);
        w_is_hexl = w_hex && (r_byte >= CH_A) && (r_byte <= CH_F);
        w_skip    = !r_in_token && is_blank(r_byte);
        w_minus   = !r_in_token && w_signed && (r_byte == CH_MINUS);
        w_emit    = !w_skip && !w_is_dig && !w_is_hexl && !w_minus;

        if (w_is_dig) begin
            w_digit = 4'(r_byte - CH_0);
        end else begin
            w_digit = 4'(r_byte - CH_A + 8'd10);
        end
        w_digit_ext = {{(VALUE_WIDTH-4){1'b0}}, w_digit};

        if (w_hex) begin
            n_acc = {r_acc[VALUE_WIDTH-5:0], w_digit};
        end else begin
            n_acc = {r_acc[VALUE_WIDTH-4:0], 3'b000} + {r_acc[VALUE_WIDTH-2:0], 1'b0}
                    + w_digit_ext;
        end

        w_value = r_minus ? ({VALUE_WIDTH{1'b0}} - r_acc) : r_acc;

        w_advance = r_in_valid && (!w_emit || !r_out_valid || i_ready);
        o_ready   = !r_in_valid || w_advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_token  <= 1'b0;
            r_minus     <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end

            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_advance) begin
                priority if (w_skip) begin
                    r_in_token <= r_in_token;
                end else if (w_is_dig || w_is_hexl) begin
                    r_acc      <= n_acc;
                    r_in_token <= 1'b1;
                end else if (w_minus) begin
                    r_minus    <= 1'b1;
                    r_in_token <= 1'b1;
                end else begin
                    r_in_token  <= 1'b0;
                    r_minus     <= 1'b0;
                    r_acc       <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_char_byte;
            r_mode <= i_number_mode;
        end
        if (w_advance && w_emit) begin
            r_out_value  <= w_value;
            r_out_tvalid <= r_in_token;
            r_out_byte   <= r_byte;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_number_value = r_out_value;
    assign o_token_valid  = r_out_tvalid;
    assign o_end_byte     = r_out_byte;

    `AITP_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, w_advance && w_emit, !r_in_token && !r_minus && (r_acc == '0))
    `AITP_ASSERT_SAME(a_minus_in_token, i_clk, i_rst_n, r_minus, r_in_token)
    `AITP_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, r_in_valid && !w_advance, r_out_valid && !i_ready && w_emit)
    `AITP_ASSERT_SAME(a_empty_token_zero, i_clk, i_rst_n, r_out_valid && !r_out_tvalid, r_out_value == '0)

endmodule

`default_nettype wire
